// ===== sv/ffve_pkg.sv =====
// Package for the urlencoded form field extractor.
// Holds shared widths, character codes, register indexes, payload types and helpers.
// No dependencies; every other file of the block refers to it by scoped names.
package ffve_pkg;

   // Defaults for the top-level parameters.
   localparam int MAX_KEY_BYTES_DEF = 8;
   localparam int OFFSET_BITS_DEF   = 16;

   // Fixed widths of the channel fields.
   localparam int BYTE_BITS      = 8;
   localparam int KEY_BITS       = 64;
   localparam int KEY_LEN_BITS   = 4;
   localparam int FIELD_BITS     = 16;
   localparam int CSR_INDEX_BITS = 4;

   // Separator characters of a urlencoded body.
   localparam logic [BYTE_BITS-1:0] AMP_CHAR = 8'h26;
   localparam logic [BYTE_BITS-1:0] EQ_CHAR  = 8'h3D;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] REG_KEY_CHARS  = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_KEY_LENGTH = 4'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MULTI_MODE = 4'd2;

   // Current configuration, as seen by the scanner.
   typedef struct packed {
      logic [KEY_BITS-1:0]     key_chars;
      logic [KEY_LEN_BITS-1:0] key_length;
      logic                    multi_mode;
   } cfg_type;

   // One result as it leaves the block.
   typedef struct packed {
      logic                  span_valid;
      logic [FIELD_BITS-1:0] value_start;
      logic [FIELD_BITS-1:0] value_length;
      logic                  body_end;
   } result_type;

   // Fold ASCII upper case letters to lower case; other bytes pass unchanged.
   function automatic logic [BYTE_BITS-1:0] fold_lower(input logic [BYTE_BITS-1:0] c);
      logic [BYTE_BITS-1:0] r;
      r = c;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = c | 8'h20;
      end
      return r;
   endfunction

endpackage

// ===== sv/ffve_if.sv =====
// Channel interfaces of the form field extractor: body bytes, results, register writes.
// Each carries valid, ready and its payload, with source and sink modports.
// Depends on ffve_pkg for field widths.
interface ffve_req_if;
   logic                           valid;
   logic                           ready;
   logic [ffve_pkg::BYTE_BITS-1:0] body_byte;
   logic                           body_last;

   modport source (output valid, output body_byte, output body_last, input ready);
   modport sink   (input valid, input body_byte, input body_last, output ready);
endinterface

interface ffve_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            span_valid;
   logic [ffve_pkg::FIELD_BITS-1:0] value_start;
   logic [ffve_pkg::FIELD_BITS-1:0] value_length;
   logic                            body_end;

   modport source (output valid, output span_valid, output value_start,
                   output value_length, output body_end, input ready);
   modport sink   (input valid, input span_valid, input value_start,
                   input value_length, input body_end, output ready);
endinterface

interface ffve_csr_if;
   logic                                valid;
   logic                                ready;
   logic [ffve_pkg::CSR_INDEX_BITS-1:0] index;
   logic [ffve_pkg::KEY_BITS-1:0]       data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/ffve_csr.sv =====
// Configuration registers of the form field extractor: key bytes, key length, mode.
// Depends on ffve_pkg for the register indexes and the cfg_type struct.
// Writes are always taken; indexes beyond the list are ignored.
module ffve_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_valid,
   input  logic [ffve_pkg::CSR_INDEX_BITS-1:0] wr_index,
   input  logic [ffve_pkg::KEY_BITS-1:0]       wr_data,
   output logic              wr_ready,
   output ffve_pkg::cfg_type cfg
);

   ffve_pkg::cfg_type cfg_ff;
   ffve_pkg::cfg_type cfg_in;

   assign wr_ready = 1'b1;
   assign cfg      = cfg_ff;

   // Decode the write index and update the addressed register.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_valid) begin
         if (wr_index == ffve_pkg::REG_KEY_CHARS) begin
            cfg_in.key_chars = wr_data;
         end else if (wr_index == ffve_pkg::REG_KEY_LENGTH) begin
            cfg_in.key_length = wr_data[ffve_pkg::KEY_LEN_BITS-1:0];
         end else if (wr_index == ffve_pkg::REG_MULTI_MODE) begin
            cfg_in.multi_mode = wr_data[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key_chars  <= '0;
         cfg_ff.key_length <= ffve_pkg::KEY_LEN_BITS'(1);
         cfg_ff.multi_mode <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== sv/ffve_scan.sv =====
// Segment scanner of the form field extractor: key compare, value tracking, span report.
// Holds the per-body state and computes at most one result per byte in a single pass.
// Depends on ffve_pkg for character codes, types and the case-folding helper.
module ffve_scan #(
   parameter int MAX_KEY_BYTES = ffve_pkg::MAX_KEY_BYTES_DEF,
   parameter int OFFSET_BITS   = ffve_pkg::OFFSET_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic [ffve_pkg::BYTE_BITS-1:0] body_byte,
   input  logic                           body_last,
   input  ffve_pkg::cfg_type              cfg,
   output logic                           has_result,
   output ffve_pkg::result_type           result
);

   localparam int KIW = $clog2(MAX_KEY_BYTES + 1);
   localparam int KEY_SLOTS = ffve_pkg::KEY_BITS / ffve_pkg::BYTE_BITS;

   // Segment state codes.
   localparam logic [1:0] MODE_COMPARE = 2'd0;
   localparam logic [1:0] MODE_VALUE   = 2'd1;
   localparam logic [1:0] MODE_SKIP    = 2'd2;

   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [KIW-1:0]         key_idx_ff, key_idx_in;
   logic [1:0]             mode_ff, mode_in;
   logic [OFFSET_BITS-1:0] open_start_ff, open_start_in;
   logic                   first_rep_ff, first_rep_in;

   logic [KIW-1:0]                    key_idx_scan;
   logic [1:0]                        mode_scan;
   logic [OFFSET_BITS-1:0]            open_start_scan;
   logic [ffve_pkg::KEY_LEN_BITS-1:0] klen;
   logic [OFFSET_BITS-1:0]            pos_next;
   logic [OFFSET_BITS-1:0]            close_end;
   logic [OFFSET_BITS-1:0]            span_len;
   logic [ffve_pkg::BYTE_BITS-1:0]    key_byte;
   logic [ffve_pkg::BYTE_BITS-1:0]    key_bytes [KEY_SLOTS];
   logic                              closed;
   logic                              report;

   // Split the key register into bytes, first byte lowest.
   always_comb begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
         key_bytes[i] = cfg.key_chars[i*ffve_pkg::BYTE_BITS +: ffve_pkg::BYTE_BITS];
      end
   end

   // Clamp the key length into the supported range.
   always_comb begin
      if (cfg.key_length == '0) begin
         klen = ffve_pkg::KEY_LEN_BITS'(1);
      end else if (cfg.key_length > ffve_pkg::KEY_LEN_BITS'(MAX_KEY_BYTES)) begin
         klen = ffve_pkg::KEY_LEN_BITS'(MAX_KEY_BYTES);
      end else begin
         klen = cfg.key_length;
      end
   end

   // Saturating position of the byte after the current one.
   assign pos_next = (pos_ff == '1) ? pos_ff : pos_ff + 1'b1;
   assign key_byte = key_bytes[3'(key_idx_ff)];

   // Segment state transitions and span closing.
   always_comb begin
      key_idx_scan    = key_idx_ff;
      mode_scan       = mode_ff;
      open_start_scan = open_start_ff;
      closed          = 1'b0;
      close_end       = '0;

      unique case (mode_ff)
         MODE_COMPARE: begin
            if (body_byte == ffve_pkg::AMP_CHAR) begin
               key_idx_scan = '0;
            end else if (ffve_pkg::KEY_LEN_BITS'(key_idx_ff) >= klen) begin
               if (body_byte == ffve_pkg::EQ_CHAR) begin
                  open_start_scan = pos_next;
                  mode_scan       = MODE_VALUE;
               end else begin
                  mode_scan = MODE_SKIP;
               end
            end else if (ffve_pkg::fold_lower(body_byte) == ffve_pkg::fold_lower(key_byte)) begin
               key_idx_scan = KIW'(key_idx_ff + 1'b1);
            end else begin
               mode_scan = MODE_SKIP;
            end
         end
         MODE_VALUE: begin
            if (body_byte == ffve_pkg::AMP_CHAR) begin
               closed       = 1'b1;
               close_end    = pos_ff;
               mode_scan    = MODE_COMPARE;
               key_idx_scan = '0;
            end
         end
         default: begin
            if (body_byte == ffve_pkg::AMP_CHAR) begin
               mode_scan    = MODE_COMPARE;
               key_idx_scan = '0;
            end
         end
      endcase

      // The last byte closes a value that is still open.
      if (body_last && mode_scan == MODE_VALUE) begin
         closed    = 1'b1;
         close_end = pos_next;
      end
   end

   // Decide whether the closed span is reported and build the result.
   assign report   = closed && (cfg.multi_mode || !first_rep_ff);
   assign span_len = (close_end > open_start_scan) ? close_end - open_start_scan : '0;

   always_comb begin
      has_result          = report || body_last;
      result.span_valid   = report;
      result.value_start  = report ? ffve_pkg::FIELD_BITS'(open_start_scan) : '0;
      result.value_length = report ? ffve_pkg::FIELD_BITS'(span_len) : '0;
      result.body_end     = body_last;
   end

   // The last byte returns the per-body state to its starting point.
   always_comb begin
      first_rep_in  = first_rep_ff || report;
      pos_in        = pos_next;
      key_idx_in    = key_idx_scan;
      mode_in       = mode_scan;
      open_start_in = open_start_scan;
      if (body_last) begin
         pos_in        = '0;
         key_idx_in    = '0;
         mode_in       = MODE_COMPARE;
         open_start_in = '0;
         first_rep_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         key_idx_ff    <= '0;
         mode_ff       <= MODE_COMPARE;
         open_start_ff <= '0;
         first_rep_ff  <= 1'b0;
      end else if (advance) begin
         pos_ff        <= pos_in;
         key_idx_ff    <= key_idx_in;
         mode_ff       <= mode_in;
         open_start_ff <= open_start_in;
         first_rep_ff  <= first_rep_in;
      end
   end

endmodule

// ===== sv/form_field_value_extract.sv =====
// Top level of the urlencoded form field extractor.
// Depends on ffve_pkg, the channel interfaces in ffve_if, ffve_csr and ffve_scan.
//
//   Channel   Direction  Payload                                         Interface
//   req_chan  in         body_byte, body_last                            ffve_req_if.sink
//   rsp_chan  out        span_valid, value_start, value_length, body_end ffve_rsp_if.source
//   csr_chan  in         index, data                                     ffve_csr_if.sink
//
// A body byte is taken into an input register, scanned combinationally and its result, if
// any, lands in the output register; one byte a cycle while rsp_chan does not stall.
// The input register still takes one byte while a result waits for rsp_chan.ready.
// A stall on rsp_chan holds the input register only when a result is still waiting.
// Reset clears the configuration to key length one and single mode, and the body state.
module form_field_value_extract #(
   parameter int MAX_KEY_BYTES = ffve_pkg::MAX_KEY_BYTES_DEF,
   parameter int OFFSET_BITS   = ffve_pkg::OFFSET_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   ffve_req_if.sink   req_chan,
   ffve_rsp_if.source rsp_chan,
   ffve_csr_if.sink   csr_chan
);

   logic                           in_valid_ff, in_valid_in;
   logic [ffve_pkg::BYTE_BITS-1:0] in_byte_ff;
   logic                           in_last_ff;
   logic                           out_valid_ff, out_valid_in;
   ffve_pkg::result_type           out_data_ff;

   ffve_pkg::cfg_type    cfg;
   ffve_pkg::result_type scan_result;
   logic                 scan_has_result;
   logic                 advance;
   logic                 csr_ready;

   // Configuration registers.
   ffve_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_chan.valid),
      .wr_index (csr_chan.index),
      .wr_data  (csr_chan.data),
      .wr_ready (csr_ready),
      .cfg      (cfg)
   );

   assign csr_chan.ready = csr_ready;

   // Scanner works on the byte in the input register.
   ffve_scan #(
      .MAX_KEY_BYTES (MAX_KEY_BYTES),
      .OFFSET_BITS   (OFFSET_BITS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .body_byte  (in_byte_ff),
      .body_last  (in_last_ff),
      .cfg        (cfg),
      .has_result (scan_has_result),
      .result     (scan_result)
   );

   // The held byte moves on when the output register is free or being emptied.
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   // Input register occupancy.
   always_comb begin
      in_valid_in = in_valid_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_chan.valid && req_chan.ready) begin
         in_valid_in = 1'b1;
      end
   end

   // Output register occupancy.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
      if (advance && scan_has_result) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.body_byte;
         in_last_ff <= req_chan.body_last;
      end
      if (advance && scan_has_result) begin
         out_data_ff <= scan_result;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.span_valid   = out_data_ff.span_valid;
   assign rsp_chan.value_start  = out_data_ff.value_start;
   assign rsp_chan.value_length = out_data_ff.value_length;
   assign rsp_chan.body_end     = out_data_ff.body_end;

endmodule

// ===== sv/ffve_check.sv =====
// Port-level checks of the form field extractor, bound to the top level.
// Depends on ffve_pkg for field widths and on form_field_value_extract as bind target.
// Only the top level's ports are observed.
module ffve_check (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic                            rsp_span_valid,
   input logic [ffve_pkg::FIELD_BITS-1:0] rsp_value_start,
   input logic [ffve_pkg::FIELD_BITS-1:0] rsp_value_length,
   input logic                            rsp_body_end
);

   // A stalled result stays offered with the same contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_span_valid) &&
         $stable(rsp_value_start) && $stable(rsp_value_length) && $stable(rsp_body_end))
      else $error("result changed while stalled");

   // No result is offered right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

   // A result without a span only comes from the end of a body.
   a_no_span_is_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_span_valid |-> rsp_body_end)
      else $error("empty result not at body end");

   // A result without a span carries zero offset and length.
   a_no_span_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_span_valid |-> rsp_value_start == '0 && rsp_value_length == '0)
      else $error("empty result carries a span");

endmodule

bind form_field_value_extract ffve_check u_ffve_check (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_span_valid   (rsp_chan.span_valid),
   .rsp_value_start  (rsp_chan.value_start),
   .rsp_value_length (rsp_chan.value_length),
   .rsp_body_end     (rsp_chan.body_end)
);
